// ===== hdl/limit_order_book_levels_assert.svh =====
// assertion helpers for the order book, sampled on aclk and idle in reset
`ifndef LIMIT_ORDER_BOOK_LEVELS_ASSERT_SVH
`define LIMIT_ORDER_BOOK_LEVELS_ASSERT_SVH

// property that must hold at every sampled edge
`define LOB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// antecedent now implies consequent in the next cycle
`define LOB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lob_pkg.sv =====
`default_nettype none

package lob_pkg;

    localparam int DEF_MAX_ORDERS = 64;
    localparam int DEF_MAX_LEVELS = 32;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_MODIFY = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic        used;
        logic [30:0] price;
        logic [31:0] total;
    } lob_lvl_rd_t;

    typedef struct packed {
        logic        wr;
        logic        kill;
        logic [30:0] price;
        logic [31:0] total;
    } lob_lvl_op_t;

    typedef struct packed {
        logic [63:0] key;
        logic        side;
        logic [30:0] price;
        logic [31:0] volume;
    } lob_slot_t;

    function automatic logic [31:0] lob_sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/lob_level_table.sv =====
`default_nettype none

module lob_level_table import lob_pkg::*; #(
    parameter int MAX_LEVELS = DEF_MAX_LEVELS,
    localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          clr_all,
    input  wire logic [IW-1:0] rd_idx,
    input  wire logic [IW-1:0] wr_idx,
    input  wire lob_lvl_op_t   op,
    output lob_lvl_rd_t        rd
);

    logic [MAX_LEVELS-1:0] used_reg;
    logic [MAX_LEVELS-1:0] used_next;
    logic [62:0]           lvl_mem [MAX_LEVELS];
    logic                  used_rd_reg;
    logic [62:0]           data_rd_reg;

    always_comb begin
        used_next = used_reg;
        if (clr_all) begin
            used_next = '0;
        end else if (op.wr) begin
            used_next[wr_idx] = 1'b1;
        end else if (op.kill) begin
            used_next[wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            used_rd_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            used_rd_reg <= used_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (op.wr) begin
            lvl_mem[wr_idx] <= {op.price, op.total};
        end
        data_rd_reg <= lvl_mem[rd_idx];
    end

    assign rd = {used_rd_reg, data_rd_reg};

endmodule

`default_nettype wire

// ===== hdl/limit_order_book_levels.sv =====
// path from input transfer to result: add and delete run the order scan, order decision, level
// match scan, level decision and best scan; an applied modify adds the S_ADD2 write; a status
// settled by the order scan alone skips the level scans; a clear goes straight to the best scan,
// where a result waits while the previous one is not taken. Flow: one item in flight, ready again
// in the cycle the result is presented; busy in the order, level match and best scans
// reset: synchronous active-low aresetn empties all tables through valid bits, ready right after
`default_nettype none
`include "limit_order_book_levels_assert.svh"

module limit_order_book_levels import lob_pkg::*; #(
    parameter int MAX_ORDERS = DEF_MAX_ORDERS,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [63:0] s_order_id,
    input  wire logic        s_side,
    input  wire logic [30:0] s_price,
    input  wire logic [31:0] s_quantity,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic             m_bid_present,
    output logic [30:0]      m_best_bid_price,
    output logic [31:0]      m_best_bid_volume,
    output logic             m_ask_present,
    output logic [30:0]      m_best_ask_price,
    output logic [31:0]      m_best_ask_volume
);

    localparam int OW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int MW = (OW > LW) ? OW : LW;
    localparam int CW = MW + 1;
    localparam logic [CW-1:0] ORD_N = CW'(MAX_ORDERS);
    localparam logic [CW-1:0] LVL_N = CW'(MAX_LEVELS);
    localparam logic [CW-1:0] SCAN_MAX = (MAX_ORDERS > MAX_LEVELS) ? ORD_N : LVL_N;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OSCAN = 3'd1;
    localparam logic [2:0] S_ODEC  = 3'd2;
    localparam logic [2:0] S_LSCAN = 3'd3;
    localparam logic [2:0] S_LDEC  = 3'd4;
    localparam logic [2:0] S_ADD2  = 3'd5;
    localparam logic [2:0] S_BEST  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pidx_reg, pidx_next;

    logic [1:0]  mode_reg, mode_next;
    logic [63:0] id_reg, id_next;
    logic        side_reg, side_next;
    logic [30:0] price_reg, price_next;
    logic [31:0] qty_reg, qty_next;
    logic [1:0]  status_reg, status_next;

    logic          ofound_reg, ofound_next;
    logic [OW-1:0] oslot_reg, oslot_next;
    logic          ofree_reg, ofree_next;
    logic [OW-1:0] fslot_reg, fslot_next;
    logic          os_reg, os_next;
    logic [30:0]   oprice_reg, oprice_next;
    logic [31:0]   ovol_reg, ovol_next;

    logic          nm_reg, nm_next;
    logic [LW-1:0] nidx_reg, nidx_next;
    logic [31:0]   ntot_reg, ntot_next;
    logic          nf_reg, nf_next;
    logic [LW-1:0] nfidx_reg, nfidx_next;
    logic          om_reg, om_next;
    logic [LW-1:0] olidx_reg, olidx_next;
    logic [31:0]   otot_reg, otot_next;
    logic [LW-1:0] aidx_reg, aidx_next;
    logic [31:0]   atot_reg, atot_next;

    logic        bb_reg, bb_next;
    logic [30:0] bbp_reg, bbp_next;
    logic [31:0] bbv_reg, bbv_next;
    logic        ba_reg, ba_next;
    logic [30:0] bap_reg, bap_next;
    logic [31:0] bav_reg, bav_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic        m_bp_reg, m_bp_next;
    logic [30:0] m_bpr_reg, m_bpr_next;
    logic [31:0] m_bv_reg, m_bv_next;
    logic        m_ap_reg, m_ap_next;
    logic [30:0] m_apr_reg, m_apr_next;
    logic [31:0] m_av_reg, m_av_next;

    logic [MAX_ORDERS-1:0] slot_used_reg, slot_used_next;
    lob_slot_t             slot_mem [MAX_ORDERS];
    lob_slot_t             slot_rd_reg;
    logic                  slot_we;
    logic [OW-1:0]         slot_waddr;
    lob_slot_t             slot_wdata;

    logic          lvl_clr;
    logic          lvl_side;
    logic [LW-1:0] lvl_widx;
    lob_lvl_op_t   lvl_op;
    lob_lvl_op_t   bid_op, ask_op;
    lob_lvl_rd_t   bid_rd, ask_rd;
    lob_lvl_rd_t   nsel, osel;

    logic          accept;
    logic [OW-1:0] po;
    logic [LW-1:0] pl;
    logic          removed;
    logic [31:0]   sub_tot;
    logic          same_lvl;
    logic          mod_ok;

    assign accept   = s_valid && s_ready;
    assign po       = pidx_reg[OW-1:0];
    assign pl       = pidx_reg[LW-1:0];
    assign nsel     = side_reg ? ask_rd : bid_rd;
    assign osel     = os_reg ? ask_rd : bid_rd;
    assign removed  = om_reg && (otot_reg <= ovol_reg);
    assign sub_tot  = otot_reg - ovol_reg;
    assign same_lvl = nm_reg && om_reg && (os_reg == side_reg) && (nidx_reg == olidx_reg);
    assign mod_ok   = nm_reg || nf_reg || ((os_reg == side_reg) && removed);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        mode_next   = mode_reg;
        id_next     = id_reg;
        side_next   = side_reg;
        price_next  = price_reg;
        qty_next    = qty_reg;
        status_next = status_reg;
        ofound_next = ofound_reg;
        oslot_next  = oslot_reg;
        ofree_next  = ofree_reg;
        fslot_next  = fslot_reg;
        os_next     = os_reg;
        oprice_next = oprice_reg;
        ovol_next   = ovol_reg;
        nm_next     = nm_reg;
        nidx_next   = nidx_reg;
        ntot_next   = ntot_reg;
        nf_next     = nf_reg;
        nfidx_next  = nfidx_reg;
        om_next     = om_reg;
        olidx_next  = olidx_reg;
        otot_next   = otot_reg;
        aidx_next   = aidx_reg;
        atot_next   = atot_reg;
        bb_next     = bb_reg;
        bbp_next    = bbp_reg;
        bbv_next    = bbv_reg;
        ba_next     = ba_reg;
        bap_next    = bap_reg;
        bav_next    = bav_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_bp_next     = m_bp_reg;
        m_bpr_next    = m_bpr_reg;
        m_bv_next     = m_bv_reg;
        m_ap_next     = m_ap_reg;
        m_apr_next    = m_apr_reg;
        m_av_next     = m_av_reg;
        slot_used_next = slot_used_reg;
        slot_we    = 1'b0;
        slot_waddr = fslot_reg;
        slot_wdata = '{key: id_reg, side: side_reg, price: price_reg, volume: qty_reg};
        lvl_clr  = 1'b0;
        lvl_side = side_reg;
        lvl_widx = olidx_reg;
        lvl_op   = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                ofound_next = 1'b0;
                ofree_next  = 1'b0;
                if (accept) begin
                    mode_next   = s_mode;
                    id_next     = s_order_id;
                    side_next   = s_side;
                    price_next  = s_price;
                    qty_next    = s_quantity;
                    status_next = ST_APPLIED;
                    if (s_mode == MODE_CLEAR) begin
                        lvl_clr        = 1'b1;
                        slot_used_next = '0;
                        state_next     = S_BEST;
                    end else begin
                        state_next = S_OSCAN;
                    end
                end
            end
            S_OSCAN: begin
                if (pend_reg) begin
                    if (slot_used_reg[po] && (slot_rd_reg.key == id_reg) && !ofound_reg) begin
                        ofound_next = 1'b1;
                        oslot_next  = po;
                        os_next     = slot_rd_reg.side;
                        oprice_next = slot_rd_reg.price;
                        ovol_next   = slot_rd_reg.volume;
                    end
                    if (!slot_used_reg[po] && !ofree_reg) begin
                        ofree_next = 1'b1;
                        fslot_next = po;
                    end
                end
                if (cnt_reg < ORD_N) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_ODEC;
                    end
                end
            end
            S_ODEC: begin
                nm_next = 1'b0;
                nf_next = 1'b0;
                om_next = 1'b0;
                if (mode_reg == MODE_ADD) begin
                    if (ofound_reg) begin
                        status_next = ST_IGNORED;
                        state_next  = S_BEST;
                    end else if (!ofree_reg) begin
                        status_next = ST_FULL;
                        state_next  = S_BEST;
                    end else begin
                        state_next = S_LSCAN;
                    end
                end else if (!ofound_reg) begin
                    status_next = ST_IGNORED;
                    state_next  = S_BEST;
                end else begin
                    state_next = S_LSCAN;
                end
            end
            S_LSCAN: begin
                if (pend_reg) begin
                    if (nsel.used && (nsel.price == price_reg) && !nm_reg) begin
                        nm_next   = 1'b1;
                        nidx_next = pl;
                        ntot_next = nsel.total;
                    end
                    if (!nsel.used && !nf_reg) begin
                        nf_next    = 1'b1;
                        nfidx_next = pl;
                    end
                    if (osel.used && (osel.price == oprice_reg) && !om_reg) begin
                        om_next    = 1'b1;
                        olidx_next = pl;
                        otot_next  = osel.total;
                    end
                end
                if (cnt_reg < LVL_N) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_LDEC;
                    end
                end
            end
            S_LDEC: begin
                state_next = S_BEST;
                case (mode_reg)
                    MODE_ADD: begin
                        if (!nm_reg && !nf_reg) begin
                            status_next = ST_FULL;
                        end else begin
                            slot_we    = 1'b1;
                            slot_waddr = fslot_reg;
                            slot_used_next[fslot_reg] = 1'b1;
                            lvl_side     = side_reg;
                            lvl_widx     = nm_reg ? nidx_reg : nfidx_reg;
                            lvl_op.wr    = 1'b1;
                            lvl_op.price = price_reg;
                            lvl_op.total = nm_reg ? lob_sat_add(ntot_reg, qty_reg) : qty_reg;
                        end
                    end
                    MODE_DELETE: begin
                        slot_used_next[oslot_reg] = 1'b0;
                        lvl_side     = os_reg;
                        lvl_widx     = olidx_reg;
                        lvl_op.wr    = om_reg && !removed;
                        lvl_op.kill  = removed;
                        lvl_op.price = oprice_reg;
                        lvl_op.total = sub_tot;
                    end
                    default: begin
                        if (!mod_ok) begin
                            status_next = ST_FULL;
                        end else begin
                            slot_we      = 1'b1;
                            slot_waddr   = oslot_reg;
                            lvl_side     = os_reg;
                            lvl_widx     = olidx_reg;
                            lvl_op.wr    = om_reg && !removed;
                            lvl_op.kill  = removed;
                            lvl_op.price = oprice_reg;
                            lvl_op.total = sub_tot;
                            // add target as seen after the old volume is taken out
                            if (same_lvl && !removed) begin
                                aidx_next = nidx_reg;
                                atot_next = lob_sat_add(sub_tot, qty_reg);
                            end else if (nm_reg && !same_lvl) begin
                                aidx_next = nidx_reg;
                                atot_next = lob_sat_add(ntot_reg, qty_reg);
                            end else begin
                                if ((os_reg == side_reg) && removed
                                        && (!nf_reg || (olidx_reg < nfidx_reg))) begin
                                    aidx_next = olidx_reg;
                                end else begin
                                    aidx_next = nfidx_reg;
                                end
                                atot_next = qty_reg;
                            end
                            state_next = S_ADD2;
                        end
                    end
                endcase
            end
            S_ADD2: begin
                lvl_side     = side_reg;
                lvl_widx     = aidx_reg;
                lvl_op.wr    = 1'b1;
                lvl_op.price = price_reg;
                lvl_op.total = atot_reg;
                state_next   = S_BEST;
            end
            S_BEST: begin
                if (pend_reg) begin
                    if (bid_rd.used && (!bb_reg || (bid_rd.price > bbp_reg))) begin
                        bb_next  = 1'b1;
                        bbp_next = bid_rd.price;
                        bbv_next = bid_rd.total;
                    end
                    if (ask_rd.used && (!ba_reg || (ask_rd.price < bap_reg))) begin
                        ba_next  = 1'b1;
                        bap_next = ask_rd.price;
                        bav_next = ask_rd.total;
                    end
                end
                if (cnt_reg < LVL_N) begin
                    cnt_next  = cnt_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg && (!m_valid_reg || m_ready)) begin
                        m_valid_next  = 1'b1;
                        m_status_next = status_reg;
                        m_bp_next     = bb_reg;
                        m_bpr_next    = bbp_reg;
                        m_bv_next     = bbv_reg;
                        m_ap_next     = ba_reg;
                        m_apr_next    = bap_reg;
                        m_av_next     = bav_reg;
                        state_next    = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // scan bookkeeping restarts on every state change
        if (state_next != state_reg) begin
            cnt_next  = '0;
            pend_next = 1'b0;
        end
        if (state_reg != S_BEST) begin
            bb_next  = 1'b0;
            bbp_next = '0;
            bbv_next = '0;
            ba_next  = 1'b0;
            bap_next = '0;
            bav_next = '0;
        end
    end

    assign bid_op = lvl_side ? lob_lvl_op_t'('0) : lvl_op;
    assign ask_op = lvl_side ? lvl_op : lob_lvl_op_t'('0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            slot_used_reg <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
            slot_used_reg <= slot_used_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg     <= pidx_next;
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        side_reg     <= side_next;
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        status_reg   <= status_next;
        ofound_reg   <= ofound_next;
        oslot_reg    <= oslot_next;
        ofree_reg    <= ofree_next;
        fslot_reg    <= fslot_next;
        os_reg       <= os_next;
        oprice_reg   <= oprice_next;
        ovol_reg     <= ovol_next;
        nm_reg       <= nm_next;
        nidx_reg     <= nidx_next;
        ntot_reg     <= ntot_next;
        nf_reg       <= nf_next;
        nfidx_reg    <= nfidx_next;
        om_reg       <= om_next;
        olidx_reg    <= olidx_next;
        otot_reg     <= otot_next;
        aidx_reg     <= aidx_next;
        atot_reg     <= atot_next;
        bb_reg       <= bb_next;
        bbp_reg      <= bbp_next;
        bbv_reg      <= bbv_next;
        ba_reg       <= ba_next;
        bap_reg      <= bap_next;
        bav_reg      <= bav_next;
        m_status_reg <= m_status_next;
        m_bp_reg     <= m_bp_next;
        m_bpr_reg    <= m_bpr_next;
        m_bv_reg     <= m_bv_next;
        m_ap_reg     <= m_ap_next;
        m_apr_reg    <= m_apr_next;
        m_av_reg     <= m_av_next;
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[cnt_reg[OW-1:0]];
    end

    lob_level_table #(.MAX_LEVELS(MAX_LEVELS)) u_bid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr_all (lvl_clr),
        .rd_idx  (cnt_reg[LW-1:0]),
        .wr_idx  (lvl_widx),
        .op      (bid_op),
        .rd      (bid_rd)
    );

    lob_level_table #(.MAX_LEVELS(MAX_LEVELS)) u_ask (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr_all (lvl_clr),
        .rd_idx  (cnt_reg[LW-1:0]),
        .wr_idx  (lvl_widx),
        .op      (ask_op),
        .rd      (ask_rd)
    );

    assign s_ready           = aresetn && (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_bid_present     = m_bp_reg;
    assign m_best_bid_price  = m_bpr_reg;
    assign m_best_bid_volume = m_bv_reg;
    assign m_ask_present     = m_ap_reg;
    assign m_best_ask_price  = m_apr_reg;
    assign m_best_ask_volume = m_av_reg;

    `LOB_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready, "ready after transfer")
    `LOB_ASSERT(a_bid_empty_zero, m_valid && !m_bid_present |-> m_best_bid_price == '0 && m_best_bid_volume == '0, "bid data without level")
    `LOB_ASSERT(a_ask_empty_zero, m_valid && !m_ask_present |-> m_best_ask_price == '0 && m_best_ask_volume == '0, "ask data without level")
    `LOB_ASSERT(a_scan_bound, cnt_reg <= SCAN_MAX, "scan counter overrun")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import lob_pkg::*;

    localparam int N_ORD = DEF_MAX_ORDERS;
    localparam int N_LVL = DEF_MAX_LEVELS;
    localparam int N_RANDOM = 1370;
    localparam int STALL_LIMIT = 40000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] id;
        logic        side;
        logic [30:0] price;
        logic [31:0] qty;
    } order_evt_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        bid_present;
        logic [30:0] bid_price;
        logic [31:0] bid_volume;
        logic        ask_present;
        logic [30:0] ask_price;
        logic [31:0] ask_volume;
    } book_top_t;

    typedef struct {
        order_evt_t evt;
        bit         fixed;
        book_top_t  top;
    } table_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [63:0] s_order_id;
    logic        s_side;
    logic [30:0] s_price;
    logic [31:0] s_quantity;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic        m_bid_present;
    logic [30:0] m_best_bid_price;
    logic [31:0] m_best_bid_volume;
    logic        m_ask_present;
    logic [30:0] m_best_ask_price;
    logic [31:0] m_best_ask_volume;

    limit_order_book_levels dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_order_id(s_order_id),
        .s_side(s_side), .s_price(s_price), .s_quantity(s_quantity),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_bid_present(m_bid_present), .m_best_bid_price(m_best_bid_price),
        .m_best_bid_volume(m_best_bid_volume), .m_ask_present(m_ask_present),
        .m_best_ask_price(m_best_ask_price), .m_best_ask_volume(m_best_ask_volume)
    );

    // shadow book
    bit          ord_used [N_ORD];
    logic [63:0] ord_id   [N_ORD];
    logic        ord_side [N_ORD];
    logic [30:0] ord_price[N_ORD];
    logic [31:0] ord_vol  [N_ORD];
    bit          lvl_used [2][N_LVL];
    logic [30:0] lvl_price[2][N_LVL];
    logic [31:0] lvl_total[2][N_LVL];

    book_top_t   top_queue[$];
    bit          top_fixed[$];
    book_top_t   fixed_queue[$];
    table_row_t  rows[$];
    int          errors;
    int          n_sent;
    int          n_got;
    int          n_adds;
    int          n_full;
    int          n_ignored;
    int          idle_cycles;
    logic [63:0] id_pool[16];

    function automatic int find_order(logic [63:0] id);
        for (int i = 0; i < N_ORD; i++)
            if (ord_used[i] && ord_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int free_order();
        for (int i = 0; i < N_ORD; i++)
            if (!ord_used[i]) return i;
        return -1;
    endfunction

    function automatic int find_level(logic s, logic [30:0] p);
        for (int i = 0; i < N_LVL; i++)
            if (lvl_used[s][i] && lvl_price[s][i] == p) return i;
        return -1;
    endfunction

    function automatic int free_level(logic s);
        for (int i = 0; i < N_LVL; i++)
            if (!lvl_used[s][i]) return i;
        return -1;
    endfunction

    function automatic void level_add(logic s, logic [30:0] p, logic [31:0] q);
        int i;
        logic [32:0] sum;
        i = find_level(s, p);
        if (i < 0) begin
            i = free_level(s);
            if (i < 0) return;
            lvl_used[s][i] = 1;
            lvl_price[s][i] = p;
            lvl_total[s][i] = '0;
        end
        sum = {1'b0, lvl_total[s][i]} + {1'b0, q};
        lvl_total[s][i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void level_sub(logic s, logic [30:0] p, logic [31:0] q);
        int i;
        i = find_level(s, p);
        if (i < 0) return;
        if (lvl_total[s][i] <= q) lvl_used[s][i] = 0;
        else lvl_total[s][i] -= q;
    endfunction

    function automatic void clear_book();
        for (int i = 0; i < N_ORD; i++) ord_used[i] = 0;
        for (int i = 0; i < N_LVL; i++) begin
            lvl_used[0][i] = 0;
            lvl_used[1][i] = 0;
        end
    endfunction

    function automatic book_top_t apply_event(order_evt_t e);
        book_top_t r;
        int o;
        int li;
        int bb;
        int ba;
        bit ok;
        logic os;
        r = '0;
        r.status = ST_APPLIED;
        case (e.mode)
            MODE_ADD: begin
                if (find_order(e.id) >= 0) begin
                    r.status = ST_IGNORED;
                end else begin
                    o = free_order();
                    if (o < 0 || (find_level(e.side, e.price) < 0 && free_level(e.side) < 0)) begin
                        r.status = ST_FULL;
                    end else begin
                        ord_used[o] = 1;
                        ord_id[o] = e.id;
                        ord_side[o] = e.side;
                        ord_price[o] = e.price;
                        ord_vol[o] = e.qty;
                        level_add(e.side, e.price, e.qty);
                    end
                end
            end
            MODE_MODIFY: begin
                o = find_order(e.id);
                if (o < 0) begin
                    r.status = ST_IGNORED;
                end else begin
                    os = ord_side[o];
                    li = find_level(os, ord_price[o]);
                    ok = find_level(e.side, e.price) >= 0 || free_level(e.side) >= 0 ||
                         (os == e.side && li >= 0 && lvl_total[os][li] <= ord_vol[o]);
                    if (!ok) begin
                        r.status = ST_FULL;
                    end else begin
                        level_sub(os, ord_price[o], ord_vol[o]);
                        ord_side[o] = e.side;
                        ord_price[o] = e.price;
                        ord_vol[o] = e.qty;
                        level_add(e.side, e.price, e.qty);
                    end
                end
            end
            MODE_DELETE: begin
                o = find_order(e.id);
                if (o < 0) begin
                    r.status = ST_IGNORED;
                end else begin
                    level_sub(ord_side[o], ord_price[o], ord_vol[o]);
                    ord_used[o] = 0;
                end
            end
            default: clear_book();
        endcase
        bb = -1;
        ba = -1;
        for (int i = 0; i < N_LVL; i++) begin
            if (lvl_used[0][i] && (bb < 0 || lvl_price[0][i] > lvl_price[0][bb])) bb = i;
            if (lvl_used[1][i] && (ba < 0 || lvl_price[1][i] < lvl_price[1][ba])) ba = i;
        end
        if (bb >= 0) begin
            r.bid_present = 1;
            r.bid_price = lvl_price[0][bb];
            r.bid_volume = lvl_total[0][bb];
        end
        if (ba >= 0) begin
            r.ask_present = 1;
            r.ask_price = lvl_price[1][ba];
            r.ask_volume = lvl_total[1][ba];
        end
        if (e.mode == MODE_ADD) n_adds++;
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_IGNORED) n_ignored++;
        return r;
    endfunction

    function automatic void add_row(order_evt_t e, bit fixed, book_top_t t);
        table_row_t r;
        r.evt = e;
        r.fixed = fixed;
        r.top = t;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // result side: stall pattern with quiet stretches
    int stall_phase;
    initial begin
        m_ready = 0;
        stall_phase = 0;
        forever begin
            @(posedge aclk);
            stall_phase = (stall_phase + 1) % 600;
            if (stall_phase < 150) m_ready <= 1'b1;
            else if (stall_phase < 400) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge aclk) begin
        book_top_t got;
        book_top_t want;
        book_top_t fixed_top;
        bit fixed;
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_bid_present, m_best_bid_price, m_best_bid_volume,
                   m_ask_present, m_best_ask_price, m_best_ask_volume};
            n_got++;
            if (top_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer %h", got);
            end else begin
                want = top_queue.pop_front();
                fixed = top_fixed.pop_front();
                if (fixed) begin
                    fixed_top = fixed_queue.pop_front();
                    if (fixed_top != want) begin
                        errors++;
                        if (errors <= 10)
                            $display("table row %0d disagrees with predictor", n_got);
                    end
                end
                if (got.status != want.status || got.bid_present != want.bid_present ||
                    got.bid_price != want.bid_price || got.bid_volume != want.bid_volume ||
                    got.ask_present != want.ask_present || got.ask_price != want.ask_price ||
                    got.ask_volume != want.ask_volume) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d mismatch: ", n_got,
                            "exp st=%0d bid=%0d/%0d/%0d ask=%0d/%0d/%0d ",
                            want.status, want.bid_present, want.bid_price, want.bid_volume,
                            want.ask_present, want.ask_price, want.ask_volume,
                            "got st=%0d bid=%0d/%0d/%0d ask=%0d/%0d/%0d",
                            got.status, got.bid_present, got.bid_price, got.bid_volume,
                            got.ask_present, got.ask_price, got.ask_volume);
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    int burst_left;

    // valid is already low whenever a burst has ended
    task automatic send_event(order_evt_t e, bit fixed, book_top_t fixed_top);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 400)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_mode <= e.mode;
        s_order_id <= e.id;
        s_side <= e.side;
        s_price <= e.price;
        s_quantity <= e.qty;
        top_queue.insert(top_queue.size(), apply_event(e));
        top_fixed.insert(top_fixed.size(), fixed);
        if (fixed) fixed_queue.insert(fixed_queue.size(), fixed_top);
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    function automatic order_evt_t evt(logic [1:0] m, logic [63:0] id, logic s,
                                       logic [30:0] p, logic [31:0] q);
        order_evt_t e;
        e.mode = m;
        e.id = id;
        e.side = s;
        e.price = p;
        e.qty = q;
        return e;
    endfunction

    function automatic book_top_t top(logic [1:0] st, logic bp, logic [30:0] bpr,
                                      logic [31:0] bv, logic ap, logic [30:0] apr,
                                      logic [31:0] av);
        return {st, bp, bpr, bv, ap, apr, av};
    endfunction

    function automatic logic [30:0] rand_price(bit wide);
        if (wide) return 31'($urandom());
        return 31'(1000 + $urandom_range(0, 40));
    endfunction

    initial begin
        order_evt_t e;
        int kind;
        book_top_t none;
        none = '0;
        errors = 0;
        n_sent = 0;
        n_got = 0;
        n_adds = 0;
        n_full = 0;
        n_ignored = 0;
        idle_cycles = 0;
        burst_left = 0;
        clear_book();
        aresetn = 0;
        s_valid = 0;
        s_mode = MODE_CLEAR;
        s_order_id = '0;
        s_side = 0;
        s_price = '0;
        s_quantity = '0;
        for (int i = 0; i < 16; i++) id_pool[i] = {$urandom(), $urandom()};
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        add_row(evt(MODE_DELETE, 64'd5, 0, 0, 0), 1, top(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        add_row(evt(MODE_MODIFY, 64'd5, 1, 9, 9), 1, top(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        add_row(evt(MODE_ADD, '1, 0, 31'h7FFF_FFFF, '1), 1,
                top(ST_APPLIED, 1, 31'h7FFF_FFFF, '1, 0, 0, 0));
        add_row(evt(MODE_ADD, '0, 1, 0, 0), 1,
                top(ST_APPLIED, 1, 31'h7FFF_FFFF, '1, 1, 0, 0));
        add_row(evt(MODE_ADD, '1, 1, 5, 5), 1,
                top(ST_IGNORED, 1, 31'h7FFF_FFFF, '1, 1, 0, 0));
        // saturating level total
        add_row(evt(MODE_ADD, 64'd7, 0, 31'h7FFF_FFFF, 32'd10), 0, none);
        add_row(evt(MODE_DELETE, '1, 0, 0, 0), 0, none);
        add_row(evt(MODE_MODIFY, '0, 1, 31'h2AAA_AAAA, 32'hAAAA_AAAA), 0, none);
        add_row(evt(MODE_MODIFY, 64'd7, 1, 31'h5555_5555, 32'h5555_5555), 0, none);
        add_row(evt(MODE_ADD, 64'd8, 1, 31'h2AAA_AAAA, 32'd1), 0, none);
        add_row(evt(MODE_DELETE, 64'd8, 0, 0, 0), 0, none);
        add_row(evt(MODE_CLEAR, '1, 1, '1, '1), 1, top(ST_APPLIED, 0, 0, 0, 0, 0, 0));
        // fill the bid level table, then one more level is dropped
        for (int i = 0; i < N_LVL; i++)
            add_row(evt(MODE_ADD, 64'(100 + i), 0, 31'(i + 1), 32'd3), 0, none);
        add_row(evt(MODE_ADD, 64'd200, 0, 31'd999, 32'd1), 1,
                top(ST_FULL, 1, 31'(N_LVL), 32'd3, 0, 0, 0));
        // modify into a fresh price reuses the level it frees
        add_row(evt(MODE_MODIFY, 64'd100, 0, 31'd999, 32'd4), 1,
                top(ST_APPLIED, 1, 31'd999, 32'd4, 0, 0, 0));
        // fill the order table, then one more add is dropped
        for (int i = 0; i < N_ORD - N_LVL; i++)
            add_row(evt(MODE_ADD, 64'(300 + i), 0, 31'd5, 32'd0), 0, none);
        add_row(evt(MODE_ADD, 64'd999, 0, 31'd5, 32'd1), 1,
                top(ST_FULL, 1, 31'd999, 32'd4, 0, 0, 0));
        add_row(evt(MODE_CLEAR, 0, 0, 0, 0), 1, top(ST_APPLIED, 0, 0, 0, 0, 0, 0));

        foreach (rows[i]) send_event(rows[i].evt, rows[i].fixed, rows[i].top);

        // drain fully once before the random part
        if (burst_left != 0) s_valid <= 1'b0;
        burst_left = 0;
        while (top_queue.size() != 0) @(posedge aclk);

        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                e.id = {$urandom(), $urandom()};
            else
                e.id = id_pool[$urandom_range(0, 15)] + 64'($urandom_range(0, 79));
            e.side = 1'($urandom_range(0, 1));
            e.price = rand_price($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 5))
                0: e.qty = '1 - $urandom_range(0, 3);
                1: e.qty = '0;
                2: e.qty = $urandom();
                default: e.qty = $urandom_range(1, 500);
            endcase
            if (kind < 45) e.mode = MODE_ADD;
            else if (kind < 70) e.mode = MODE_MODIFY;
            else if (kind < 98) e.mode = MODE_DELETE;
            else e.mode = MODE_CLEAR;
            send_event(e, 0, none);
        end

        if (burst_left != 0) s_valid <= 1'b0;
        burst_left = 0;
        while (top_queue.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("sent %0d book events (%0d adds), checked %0d tops of book",
                 n_sent, n_adds, n_got);
        $display("covered %0d table-full drops and %0d ignored events", n_full, n_ignored);
        if (errors == 0 && top_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, top_queue.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/lob_pkg.sv
hdl/lob_level_table.sv
hdl/limit_order_book_levels.sv
sim/tb_top.sv
